>>> hw/rtl/tcun_pkg.sv
// Shared types and constants for the triangle centroid and unit normal pipeline
package tcun_pkg;

    // Fixed numeric widths of the normal path
    localparam int NORM_BITS  = 31;   // largest component normalized to this bit length
    localparam int SQR_BITS   = 64;   // sum of three squares of 31-bit values
    localparam int ROOT_BITS  = 32;   // integer square root of the sum

    // Control word that travels with each pipeline word
    typedef struct packed {
        logic valid;
        logic live;    // cross product not all zero
    } ctl_t;

endpackage

>>> hw/rtl/triangle_centroid_unit_normal.sv
// Top level: pipelined triangle centroid and unit face normal
//
// Input channel: nine signed vertex coordinates (a, b, c; x, y, z), one word per
// triangle, accepted when valid and ready are both high. Output channel: three
// centroid coordinates (same format as the input) and three Q1.F unit normal
// components. A degenerate triangle (cross product exactly zero) produces no
// output word; it simply drops out of the pipeline.
// The datapath is a chain of cells: cross product and normalize stages, then
// one square root cell per root bit (32), then one divide cell per numerator
// bit (F+33), each cell registered. Throughput is one triangle per cycle
// while the output is not stalled.
// When the receiver stalls, the whole chain holds; ready is high whenever the
// output register is empty or is being taken, so while a finished word waits
// to be taken no new word enters.
// Reset clears all valid bits; payload registers are not reset.
module triangle_centroid_unit_normal
#(
    parameter int COORD_WIDTH      = 24,
    parameter int NORMAL_FRAC_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [COORD_WIDTH-1:0] vertex_a_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_a_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_a_z,
    input  logic signed [COORD_WIDTH-1:0] vertex_b_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_b_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_b_z,
    input  logic signed [COORD_WIDTH-1:0] vertex_c_x,
    input  logic signed [COORD_WIDTH-1:0] vertex_c_y,
    input  logic signed [COORD_WIDTH-1:0] vertex_c_z,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [COORD_WIDTH-1:0] centroid_x,
    output logic signed [COORD_WIDTH-1:0] centroid_y,
    output logic signed [COORD_WIDTH-1:0] centroid_z,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0] normal_z
);
    import tcun_pkg::*;

    localparam int DW   = COORD_WIDTH + 1;          // difference width
    localparam int PW   = 2 * DW;                   // product width
    localparam int CW   = PW + 1;                   // cross component width
    localparam int MW   = CW;                       // magnitude width
    localparam int LW   = $clog2(MW + 1);           // bit length width
    localparam int SW   = COORD_WIDTH + 2;          // sum of three coords
    localparam int QB   = NORMAL_FRAC_BITS + 2;     // quotient bits
    localparam int NUMW = NORM_BITS + NORMAL_FRAC_BITS + 2;
    localparam int RW   = ROOT_BITS + 2;
    localparam int NS   = 6 + ROOT_BITS + NUMW;     // total stages before output
    localparam int DIV0 = 6 + ROOT_BITS;            // first divide stage

    // Pipeline advance: everything moves unless the output is held
    logic adv;
    logic out_full_reg;
    assign adv      = !out_full_reg || out_ready;
    assign in_ready = adv;

    // Per-stage control words
    ctl_t ctl_reg [NS];

    // Centroid payload rides along as a delay line of sums, finished at the end
    logic signed [SW-1:0] sum_reg [NS][3];

    // Stage 0: differences
    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] w_reg [3];
    // Stage 1: six products
    logic signed [PW-1:0] p_reg [6];
    // Stage 2: cross components as sign and magnitude
    logic [MW-1:0] mag_reg [3];
    logic          neg_reg [2:NS-1][3];
    // Stage 3: magnitudes held while the max bit length is found
    logic [MW-1:0] mag3_reg [3];
    // Stage 4: normalized 31-bit components
    logic [NORM_BITS-1:0] n_reg [4:NS-1][3];
    // Stage 5: squares summed (radicand)
    logic [SQR_BITS-1:0] rad_reg;
    // Square root chain
    logic [SQR_BITS-1:0]  srem_reg [ROOT_BITS];
    logic [ROOT_BITS-1:0] sroot_reg [ROOT_BITS];
    // Divide chain
    logic [RW-1:0]  drem_reg [NUMW][3];
    logic [QB-1:0]  dq_reg [NUMW][3];
    logic [ROOT_BITS:0] dvs_reg [NUMW];

    logic [COORD_WIDTH-1:0] vin [9];
    assign vin = '{vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x, vertex_b_y,
                   vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z};

    // Front stages: difference, product, cross, length, normalize, square sum
    logic signed [CW-1:0] cross_w [3];
    logic [LW-1:0]        blen [3];
    logic [LW-1:0]        mlen;
    logic [NORM_BITS-1:0] nrm [3];
    logic [SQR_BITS-1:0]  sq [3];

    always_comb
    begin
        cross_w[0] = CW'(p_reg[0]) - CW'(p_reg[1]);
        cross_w[1] = CW'(p_reg[2]) - CW'(p_reg[3]);
        cross_w[2] = CW'(p_reg[4]) - CW'(p_reg[5]);
        for (int i = 0; i < 3; i++)
        begin
            blen[i] = '0;
            for (int b = 0; b < MW; b++)
                if (mag3_reg[i][b])
                    blen[i] = LW'(b + 1);
        end
        mlen = blen[0];
        if (blen[1] > mlen) mlen = blen[1];
        if (blen[2] > mlen) mlen = blen[2];
        for (int i = 0; i < 3; i++)
        begin
            if (mlen > LW'(NORM_BITS))
                nrm[i] = NORM_BITS'(mag3_reg[i] >> (mlen - LW'(NORM_BITS)));
            else
                nrm[i] = NORM_BITS'(mag3_reg[i] << (LW'(NORM_BITS) - mlen));
            sq[i] = SQR_BITS'(n_reg[4][i]) * SQR_BITS'(n_reg[4][i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
                ctl_reg[s] <= '0;
        end
        else if (adv)
        begin
            ctl_reg[0] <= '{valid: in_valid, live: 1'b1};
            for (int s = 1; s < NS; s++)
                if (s != 3)
                    ctl_reg[s] <= ctl_reg[s-1];
            // drop degenerate words at stage 3
            ctl_reg[3] <= '{valid: ctl_reg[2].valid,
                            live: ctl_reg[2].live && (mag_reg[0] != '0 ||
                                  mag_reg[1] != '0 || mag_reg[2] != '0)};
        end
    end

    // Payload chain
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= DW'($signed(vin[3+i])) - DW'($signed(vin[i]));
                w_reg[i] <= DW'($signed(vin[6+i])) - DW'($signed(vin[i]));
                sum_reg[0][i] <= SW'($signed(vin[i])) + SW'($signed(vin[3+i]))
                               + SW'($signed(vin[6+i]));
                for (int s = 1; s < NS; s++)
                    sum_reg[s][i] <= sum_reg[s-1][i];
                mag_reg[i]    <= cross_w[i][CW-1] ? MW'(-cross_w[i]) : MW'(cross_w[i]);
                neg_reg[2][i] <= cross_w[i][CW-1];
                for (int s = 3; s < NS; s++)
                    neg_reg[s][i] <= neg_reg[s-1][i];
                mag3_reg[i]   <= mag_reg[i];
                n_reg[4][i]   <= nrm[i];
                for (int s = 5; s < NS; s++)
                    n_reg[s][i] <= n_reg[s-1][i];
            end
            p_reg[0] <= u_reg[1] * w_reg[2];
            p_reg[1] <= u_reg[2] * w_reg[1];
            p_reg[2] <= u_reg[2] * w_reg[0];
            p_reg[3] <= u_reg[0] * w_reg[2];
            p_reg[4] <= u_reg[0] * w_reg[1];
            p_reg[5] <= u_reg[1] * w_reg[0];
            rad_reg  <= sq[0] + sq[1] + sq[2];
        end
    end

    // Square root cells
    logic [SQR_BITS-1:0]  srem_next [ROOT_BITS];
    logic [ROOT_BITS-1:0] sroot_next [ROOT_BITS];

    for (genvar k = 0; k < ROOT_BITS; k++)
    begin : g_sqrt
        tcun_sqrt_cell #(.STEP(k)) u_cell (
            .rem_in  ((k == 0) ? rad_reg : srem_reg[(k == 0) ? 0 : k-1]),
            .root_in ((k == 0) ? '0 : sroot_reg[(k == 0) ? 0 : k-1]),
            .rem_out (srem_next[k]),
            .root_out(sroot_next[k])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                srem_reg[k]  <= srem_next[k];
                sroot_reg[k] <= sroot_next[k];
            end
        end
    end

    // Divide cells: q = (n << (F+1) + r) / (2r), numerator bits fed MSB first
    logic [RW-1:0]  drem_next [NUMW][3];
    logic [QB-1:0]  dq_next [NUMW][3];
    logic           nbit [NUMW][3];
    logic [NUMW-1:0] numer [NUMW][3];
    logic [RW-1:0]  rin [NUMW][3];
    logic [QB-1:0]  qin [NUMW][3];

    for (genvar k = 0; k < NUMW; k++)
    begin : g_div
        logic [ROOT_BITS:0] dvs_in;
        assign dvs_in = (k == 0) ? {sroot_reg[ROOT_BITS-1], 1'b0}
                                 : dvs_reg[(k == 0) ? 0 : k-1];
        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                numer[k][i] = ({1'b0, n_reg[DIV0+k-1][i], {(NORMAL_FRAC_BITS+1){1'b0}}})
                            + NUMW'(dvs_in[ROOT_BITS:1]);
                nbit[k][i]  = numer[k][i][NUMW-1-k];
                rin[k][i]   = (k == 0) ? '0 : drem_reg[(k == 0) ? 0 : k-1][i];
                qin[k][i]   = (k == 0) ? '0 : dq_reg[(k == 0) ? 0 : k-1][i];
            end
        end
        tcun_div_cell #(.QBITS(QB)) u_cell (
            .rem_in (rin[k]),
            .num_bit(nbit[k]),
            .dvs    (dvs_in),
            .q_in   (qin[k]),
            .rem_out(drem_next[k]),
            .q_out  (dq_next[k])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dvs_reg[k]  <= dvs_in;
                drem_reg[k] <= drem_next[k];
                dq_reg[k]   <= dq_next[k];
            end
        end
    end

    // Output register with centroid rounding
    // round(sum/3) = floor((sum+1)/3); the sum is biased by 3 * 2^(W-1) so it is
    // positive, divided by three through a reciprocal multiply, then unbiased
    localparam int RSH = SW + 2;
    localparam logic [SW:0]   RECIP3 = (SW+1)'(((64'd1 << RSH) + 64'd2) / 64'd3);
    localparam logic [SW-1:0] CBIAS  = SW'(64'd3 << (COORD_WIDTH - 1));

    logic [SW-1:0]          bsum [3];
    logic [2*SW:0]          cprod [3];
    logic [COORD_WIDTH-1:0] cq [3];
    logic [COORD_WIDTH-1:0] q3 [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bsum[i]  = $unsigned(sum_reg[NS-1][i]) + SW'(1) + CBIAS;
            cprod[i] = (2*SW+1)'(bsum[i]) * (2*SW+1)'(RECIP3);
            cq[i]    = COORD_WIDTH'(cprod[i] >> RSH);
            q3[i]    = {~cq[i][COORD_WIDTH-1], cq[i][COORD_WIDTH-2:0]};
        end
    end

    logic ctl_last;
    assign ctl_last = ctl_reg[NS-1].valid && ctl_reg[NS-1].live;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_full_reg <= 1'b0;
        else if (adv)
            out_full_reg <= ctl_last;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            centroid_x <= q3[0];
            centroid_y <= q3[1];
            centroid_z <= q3[2];
            normal_x <= neg_reg[NS-1][0] ? -dq_reg[NUMW-1][0] : dq_reg[NUMW-1][0];
            normal_y <= neg_reg[NS-1][1] ? -dq_reg[NUMW-1][1] : dq_reg[NUMW-1][1];
            normal_z <= neg_reg[NS-1][2] ? -dq_reg[NUMW-1][2] : dq_reg[NUMW-1][2];
        end
    end

    assign out_valid = out_full_reg;

    // A held output word keeps the chain frozen
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while chain frozen");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (normal_x != '0 || normal_y != '0 || normal_z != '0))
        else $error("zero normal delivered");
endmodule

>>> hw/rtl/tcun_sqrt_cell.sv
// One restoring square root cell: two radicand bits per cell
module tcun_sqrt_cell
#(
    parameter int STEP = 0
) (
    input  logic [tcun_pkg::SQR_BITS-1:0]  rem_in,
    input  logic [tcun_pkg::ROOT_BITS-1:0] root_in,
    output logic [tcun_pkg::SQR_BITS-1:0]  rem_out,
    output logic [tcun_pkg::ROOT_BITS-1:0] root_out
);
    import tcun_pkg::*;

    localparam int SH = 2 * (ROOT_BITS - 1 - STEP);

    logic [SQR_BITS+1:0] trial;
    logic [SQR_BITS+1:0] rem_w;

    // Try root bit: compare remainder against (4*root+1) << SH
    always_comb
    begin
        trial = ({2'b00, root_in, 2'b01, {(SQR_BITS - ROOT_BITS - 2){1'b0}}}
                 >> (SQR_BITS - ROOT_BITS - 2)) << SH;
        rem_w = {2'b00, rem_in};
        if (rem_w >= trial)
        begin
            rem_out  = SQR_BITS'(rem_w - trial);
            root_out = {root_in[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_out  = rem_in;
            root_out = {root_in[ROOT_BITS-2:0], 1'b0};
        end
    end
endmodule

>>> hw/rtl/tcun_div_cell.sv
// One restoring division cell: one quotient bit for three lanes
module tcun_div_cell
#(
    parameter int QBITS = 18
) (
    input  logic [tcun_pkg::ROOT_BITS+1:0] rem_in [3],
    input  logic                           num_bit [3],
    input  logic [tcun_pkg::ROOT_BITS:0]   dvs,
    input  logic [QBITS-1:0]               q_in [3],
    output logic [tcun_pkg::ROOT_BITS+1:0] rem_out [3],
    output logic [QBITS-1:0]               q_out [3]
);
    import tcun_pkg::*;

    logic [ROOT_BITS+1:0] sh [3];

    // Shift in one numerator bit, subtract divisor when it fits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sh[i] = {rem_in[i][ROOT_BITS:0], num_bit[i]};
            if (sh[i] >= {1'b0, dvs})
            begin
                rem_out[i] = sh[i] - {1'b0, dvs};
                q_out[i]   = {q_in[i][QBITS-2:0], 1'b1};
            end
            else
            begin
                rem_out[i] = sh[i];
                q_out[i]   = {q_in[i][QBITS-2:0], 1'b0};
            end
        end
    end
endmodule

>>> tb/sv/tb.sv
// Testbench for the triangle centroid and unit normal pipeline
`timescale 1ns / 100ps

module tb;

    localparam int CW = 24;
    localparam int FB = 16;
    localparam int NW = FB + 2;
    localparam int LATENCY = 6 + 32 + FB + 33;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [CW-1:0] cx, cy, cz;
        logic signed [NW-1:0] nx, ny, nz;
    } face_t;

    // Expected faces in arrival order; compares results against them
    class face_board;
        face_t pending[$];
        int    errors;

        // Centroid of three coordinates, rounded to nearest
        function logic signed [CW-1:0] third(longint sum);
            longint q;
            longint r;
            q = sum / 3;
            r = sum % 3;
            if (r < 0)
            begin
                r += 3;
                q--;
            end
            if (r == 2)
                q++;
            return q[CW-1:0];
        endfunction

        function longint unsigned isqrt(longint unsigned s);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > s)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (s >= res + bitv)
                begin
                    s -= res + bitv;
                    res = (res >> 1) + bitv;
                end
                else
                    res >>= 1;
                bitv >>= 2;
            end
            return res;
        endfunction

        // Work out the face for one accepted triangle; degenerate ones add nothing
        function void note_triangle(logic signed [CW-1:0] v[9]);
            logic signed [127:0] u[3], w[3], cr[3];
            logic [127:0] mag[3];
            longint unsigned n[3];
            longint unsigned s, r, q;
            int maxlen, len, i, b;
            face_t f;
            for (i = 0; i < 3; i++)
            begin
                u[i] = 128'(v[3+i]) - 128'(v[i]);
                w[i] = 128'(v[6+i]) - 128'(v[i]);
            end
            cr[0] = u[1] * w[2] - u[2] * w[1];
            cr[1] = u[2] * w[0] - u[0] * w[2];
            cr[2] = u[0] * w[1] - u[1] * w[0];
            maxlen = 0;
            for (i = 0; i < 3; i++)
            begin
                mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
                len = 0;
                for (b = 0; b < 128; b++)
                    if (mag[i][b])
                        len = b + 1;
                if (len > maxlen)
                    maxlen = len;
            end
            if (maxlen == 0)
                return;
            s = 0;
            for (i = 0; i < 3; i++)
            begin
                if (maxlen > 31)
                    n[i] = 64'(mag[i] >> (maxlen - 31));
                else
                    n[i] = 64'(mag[i] << (31 - maxlen));
                s += n[i] * n[i];
            end
            r = isqrt(s);
            f.cx = third(longint'(v[0]) + v[3] + v[6]);
            f.cy = third(longint'(v[1]) + v[4] + v[7]);
            f.cz = third(longint'(v[2]) + v[5] + v[8]);
            q = ((n[0] << (FB + 1)) + r) / (2 * r);
            f.nx = cr[0] < 0 ? -q[NW-1:0] : q[NW-1:0];
            q = ((n[1] << (FB + 1)) + r) / (2 * r);
            f.ny = cr[1] < 0 ? -q[NW-1:0] : q[NW-1:0];
            q = ((n[2] << (FB + 1)) + r) / (2 * r);
            f.nz = cr[2] < 0 ? -q[NW-1:0] : q[NW-1:0];
            pending.insert(pending.size(), f);
        endfunction

        function void check_face(face_t got);
            face_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word cx=%0d cy=%0d cz=%0d", got.cx, got.cy, got.cz);
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                errors++;
                if (errors <= 10)
                    $display("exp c=(%0d %0d %0d) n=(%0d %0d %0d) got c=(%0d %0d %0d) n=(%0d %0d %0d)",
                             e.cx, e.cy, e.cz, e.nx, e.ny, e.nz,
                             got.cx, got.cy, got.cz, got.nx, got.ny, got.nz);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 0;
    logic signed [CW-1:0] vtx[9];
    logic signed [CW-1:0] centroid_x, centroid_y, centroid_z;
    logic signed [NW-1:0] normal_x, normal_y, normal_z;

    face_board board = new();
    int src_idle = 0;
    int snk_idle = 0;
    int cycles = 0;

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    triangle_centroid_unit_normal dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .vertex_a_x(vtx[0]), .vertex_a_y(vtx[1]), .vertex_a_z(vtx[2]),
        .vertex_b_x(vtx[3]), .vertex_b_y(vtx[4]), .vertex_b_z(vtx[5]),
        .vertex_c_x(vtx[6]), .vertex_c_y(vtx[7]), .vertex_c_z(vtx[8]),
        .out_valid(out_valid), .out_ready(out_ready),
        .centroid_x(centroid_x), .centroid_y(centroid_y), .centroid_z(centroid_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
    );

    // Receiver: random stalls, checks each taken word
    always @(posedge clk)
    begin
        face_t got;
        if (out_valid && out_ready)
        begin
            got.cx = centroid_x;
            got.cy = centroid_y;
            got.cz = centroid_z;
            got.nx = normal_x;
            got.ny = normal_y;
            got.nz = normal_z;
            board.check_face(got);
        end
        out_ready <= rst_n && ($urandom_range(99) >= snk_idle);
    end

    // Timeout watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("triangle_centroid_unit_normal: mismatch");
            $finish;
        end
    end

    // Present one triangle, holding it until accepted
    task automatic send_triangle(logic signed [CW-1:0] t[9]);
        while ($urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        for (int i = 0; i < 9; i++)
            vtx[i] <= t[i];
        do
            @(posedge clk);
        while (!in_ready);
        board.note_triangle(t);
    endtask

    // Send a triangle given as plain integers
    task automatic send_ints(int v[9]);
        logic signed [CW-1:0] t[9];
        for (int i = 0; i < 9; i++)
            t[i] = CW'(v[i]);
        send_triangle(t);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            1: return CW'($signed(24'($urandom_range(255))) - 128);
            default: return 24'($urandom);
        endcase
    endfunction

    // Random triangle, sometimes collinear or with coincident vertices
    task automatic send_random();
        logic signed [CW-1:0] t[9];
        int k;
        for (int i = 0; i < 9; i++)
            t[i] = rand_coord();
        k = $urandom_range(19);
        if (k == 0)
            for (int i = 0; i < 3; i++)
                t[3+i] = t[i];
        else if (k == 1)
            for (int i = 0; i < 3; i++)
            begin
                t[i] = CW'($signed(24'($urandom_range(4095))) - 2048);
                t[3+i] = t[i] + t[i];
                t[6+i] = t[i] + t[i] + t[i];
            end
        send_triangle(t);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4)
            @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < 9; i++)
            vtx[i] = '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: axis-aligned faces, extremes, degenerate cases
        send_ints('{0, 0, 0, 65536, 0, 0, 0, 65536, 0});
        send_ints('{0, 0, 0, 0, 65536, 0, 65536, 0, 0});
        send_ints('{0, 0, 0, 0, 0, 65536, 65536, 0, 0});
        send_ints('{-8388608, -8388608, -8388608, 8388607, -8388608, 8388607,
                    -8388608, 8388607, 8388607});
        send_ints('{8388607, 8388607, 8388607, -8388608, 8388607, -8388608,
                    8388607, -8388608, -8388608});
        send_ints('{-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                    -8388608, -8388608, -8388608});
        send_ints('{8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                    8388607, 8388607, 8388607});
        send_ints('{1, 2, 3, 2, 4, 6, 3, 6, 9});
        send_ints('{0, 0, 0, 1, 0, 0, 0, 1, 0});
        send_ints('{0, 0, 0, 1, 1, 0, 1, 2, 0});
        send_ints('{-1, -1, -1, -2, -1, -1, -1, -2, -1});
        send_ints('{5, 5, 5, 5, 5, 5, 9, 1, 3});
        send_ints('{0, 0, 0, 8388607, 1, 0, -8388608, 8388607, 1});

        // Sender stalls less, then more, then neither
        src_idle = 24;
        snk_idle = 63;
        repeat (270)
            send_random();
        drain();
        src_idle = 63;
        snk_idle = 24;
        repeat (270)
            send_random();
        drain();
        src_idle = 0;
        snk_idle = 0;
        repeat (260)
            send_random();
        drain();

        if (board.errors == 0)
            $display("triangle_centroid_unit_normal: match");
        else
            $display("triangle_centroid_unit_normal: mismatch");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/tcun_pkg.sv
hw/rtl/tcun_sqrt_cell.sv
hw/rtl/tcun_div_cell.sv
hw/rtl/triangle_centroid_unit_normal.sv
tb/sv/tb.sv
